[hw/rtl/fsrb_pkg.sv]
// ----------------------------------------------------------------------------
// fsrb_pkg
// Command and status codes shared by the frame slot receive buffer.
// ----------------------------------------------------------------------------
package fsrb_pkg;

    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_ABORT = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_FRAME = 2'd2
    } status_t;

endpackage

[hw/rtl/frame_slot_receive_buffer_top.sv]
// ----------------------------------------------------------------------------
// frame_slot_receive_buffer_top
// Ring of fixed-length frame slots that assembles received bytes into frames
// and streams complete frames out in arrival order.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every item except a
// successful read gives its single result, marked by result_valid, in the
// cycle after it is taken, and the receiver must take each result in that
// cycle. Write byte, abort and the unused command never raise busy, so one
// such item may be issued every cycle. A successful read spends the cycle
// after it is taken on the first slot memory access, then streams FRAME_BYTES
// results on consecutive cycles, one byte per cycle from the single read port
// of the slot memory; busy stays high during the read, and the next item can
// be taken in the cycle that shows the last result. A read that finds no
// frame gives one result like a write.
// device_busy, used_frames and ready_to_read always show the state after the
// item being reported.
// ----------------------------------------------------------------------------
module frame_slot_receive_buffer_top #(
    parameter int SLOT_COUNT  = 4,
    parameter int FRAME_BYTES = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [fsrb_pkg::CMD_W-1:0]     command,
    input  logic [fsrb_pkg::BYTE_W-1:0]    rx_byte,
    output logic                           result_valid,
    output logic [fsrb_pkg::STATUS_W-1:0]  status,
    output logic [fsrb_pkg::BYTE_W-1:0]    read_byte,
    output logic                           last,
    output logic                           timer_start,
    output logic                           timer_stop,
    output logic                           device_busy,
    output logic [fsrb_pkg::USED_W-1:0]    used_frames,
    output logic                           ready_to_read
);

    import fsrb_pkg::*;

    localparam int DEPTH  = SLOT_COUNT * FRAME_BYTES;
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int FILL_W = $clog2(FRAME_BYTES);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int EXT_W  = CNT_W + USED_W;

    localparam logic [SLOT_W-1:0] SLOT_MAX  = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(SLOT_COUNT);
    localparam logic [ADDR_W-1:0] FRAME_A   = ADDR_W'(FRAME_BYTES);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    // control state
    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   wr_slot_reg, wr_slot_next;
    logic [SLOT_W-1:0]   rd_slot_reg, rd_slot_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;      // bytes held in the write slot
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                busy_flag_reg, busy_flag_next;
    logic [ADDR_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [FILL_W-1:0]   rd_idx_reg, rd_idx_next;

    // registered result
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic                last_reg, last_next;
    logic                tstart_reg, tstart_next;
    logic                tstop_reg, tstop_next;
    logic                byte_sel_reg, byte_sel_next;

    logic [BYTE_W-1:0]   mem [DEPTH];
    logic [BYTE_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;

    logic                accept;
    logic                full;
    cmd_t                cmd;
    logic [EXT_W-1:0]    count_ext;

    assign accept = start && (state_reg == S_IDLE);
    assign cmd    = cmd_t'(command);
    // ready slots run contiguously from the read slot, so the ring is full
    // exactly when the write slot still holds an unread frame
    assign full   = (count_reg == CNT_FULL);
    assign mem_waddr = (ADDR_W'(wr_slot_reg) * FRAME_A) + ADDR_W'(fill_reg);

    always_comb
    begin
        state_next     = state_reg;
        wr_slot_next   = wr_slot_reg;
        rd_slot_next   = rd_slot_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        busy_flag_next = busy_flag_reg;
        rd_addr_next   = rd_addr_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = 1'b0;
        status_next    = ST_OK;
        last_next      = 1'b0;
        tstart_next    = 1'b0;
        tstop_next     = 1'b0;
        byte_sel_next  = 1'b0;
        mem_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    unique case (cmd)
                        CMD_WRITE:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                tstart_next = (fill_reg == '0);
                                if (fill_reg == FILL_MAX)
                                begin
                                    tstop_next   = 1'b1;
                                    fill_next    = '0;
                                    count_next   = count_reg + 1'b1;
                                    wr_slot_next = (wr_slot_reg == SLOT_MAX) ? '0
                                                   : wr_slot_reg + 1'b1;
                                end
                                else
                                begin
                                    fill_next = fill_reg + 1'b1;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NO_FRAME;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                last_next      = 1'b0;
                                busy_flag_next = full;
                                count_next     = count_reg - 1'b1;
                                rd_slot_next   = (rd_slot_reg == SLOT_MAX) ? '0
                                                 : rd_slot_reg + 1'b1;
                                rd_addr_next   = ADDR_W'(rd_slot_reg) * FRAME_A;
                                rd_idx_next    = '0;
                                state_next     = S_READ;
                            end
                        end
                        CMD_ABORT:
                        begin
                            if (!full)
                            begin
                                fill_next = '0;
                            end
                        end
                        CMD_NOP:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // byte issued now shows on the ports next cycle
                out_valid_next = 1'b1;
                byte_sel_next  = 1'b1;
                last_next      = (rd_idx_reg == FILL_MAX);
                rd_addr_next   = rd_addr_reg + 1'b1;
                rd_idx_next    = rd_idx_reg + 1'b1;
                if (rd_idx_reg == FILL_MAX)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wr_slot_reg   <= '0;
            rd_slot_reg   <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            busy_flag_reg <= 1'b0;
            rd_addr_reg   <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            last_reg      <= 1'b0;
            tstart_reg    <= 1'b0;
            tstop_reg     <= 1'b0;
            byte_sel_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_slot_reg   <= wr_slot_next;
            rd_slot_reg   <= rd_slot_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            busy_flag_reg <= busy_flag_next;
            rd_addr_reg   <= rd_addr_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
            tstart_reg    <= tstart_next;
            tstop_reg     <= tstop_next;
            byte_sel_reg  <= byte_sel_next;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= rx_byte;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    assign count_ext     = EXT_W'(count_reg);
    assign busy          = (state_reg == S_READ);
    assign result_valid  = out_valid_reg;
    assign status        = status_reg;
    assign read_byte     = byte_sel_reg ? rd_data_reg : '0;
    assign last          = last_reg;
    assign timer_start   = tstart_reg;
    assign timer_stop    = tstop_reg;
    assign device_busy   = busy_flag_reg;
    assign used_frames   = count_ext[USED_W-1:0];
    assign ready_to_read = (count_reg != '0);

    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !((command == CMD_READ) && (count_reg != '0))
        |=> result_valid)
        else $error("accepted item gave no result in the next cycle");

    a_read_stream_begins: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_READ) && (count_reg != '0)
        |=> !result_valid ##1 result_valid)
        else $error("frame read did not start its stream after one cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("frame count exceeds slot count");

    a_read_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (32'(rd_addr_reg) < DEPTH))
        else $error("read address beyond slot memory");

    a_read_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && last && byte_sel_reg)
        else $error("frame read did not end with its last byte");

endmodule
